// ----- hw/rtl/smap_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// smap_pkg
// Shared types and constants for the STUN mapped-address parser.
// ----------------------------------------------------------------------------
package smap_pkg;

    // Default limit on the bytes of one packet that are counted and parsed.
    localparam int MAX_PACKET_BYTES = 1024;

    // Fixed STUN header length in bytes.
    localparam int HDR_BYTES = 20;

    localparam logic [15:0] TYPE_BINDING_RESPONSE = 16'h0101;
    localparam logic [15:0] ATTR_MAPPED           = 16'h0001;
    localparam logic [15:0] ATTR_XOR_MAPPED       = 16'h0020;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_NOT_BINDING = 2'd1,
        STATUS_BAD_LENGTH  = 2'd2,
        STATUS_NO_ADDRESS  = 2'd3
    } status_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] address;
        logic        was_xor_form;
    } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/stun_mapped_address_parser.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stun_mapped_address_parser
// Byte-wide STUN binding-response parser that extracts the mapped IPv4 address.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                                   | Moves
//  --------+-------------------------------------------+------------------------
//  input   | in_valid, in_ready, data_byte,            | one response byte per
//          | end_of_packet                             | transfer, network order
//  output  | out_valid, out_ready, status, address,    | one verdict per packet,
//          | was_xor_form                              | after the marked byte
//
//  A byte transfer is registered in an input stage and parsed by one pass of
//  logic in smap_core; one byte is taken every cycle while no marked byte waits.
//  out_valid rises once the last byte has left the input stage and its verdict
//  is written into the result register, which happens only when it is free.
//  A stalled output only holds back a marked byte, which needs the result
//  register; other bytes keep flowing while a verdict waits to be taken.
//  Reset (rst_n, asynchronous) empties both stages and clears the parse state;
//  after each marked byte the parse state returns to its reset value.
//
module stun_mapped_address_parser #(
    parameter int MAX_PACKET_BYTES = smap_pkg::MAX_PACKET_BYTES
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        end_of_packet,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [31:0]      address,
    output logic             was_xor_form
);

    // Input stage: one registered byte waiting to be parsed.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eop_reg;

    // Result register.
    logic              out_valid_reg;
    smap_pkg::result_t out_result_reg;

    smap_pkg::result_t core_result;
    logic              out_free;
    logic              step;

    // A marked byte may only be parsed when the result register can take its
    // verdict in the same edge; unmarked bytes never wait on the output.
    assign out_free = !out_valid_reg || out_ready;
    assign step     = in_valid_reg && (!in_eop_reg || out_free);
    assign in_ready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= data_byte;
            in_eop_reg  <= end_of_packet;
        end
    end

    smap_core #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .data_byte     (in_byte_reg),
        .end_of_packet (in_eop_reg),
        .result        (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step && in_eop_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && in_eop_reg)
        begin
            out_result_reg <= core_result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_result_reg.status;
    assign address      = out_result_reg.address;
    assign was_xor_form = out_result_reg.was_xor_form;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        step && in_eop_reg |-> out_free)
        else $error("verdict written over one not yet taken");

    a_verdict_follows_eop: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(step && in_eop_reg))
        else $error("verdict appeared without a marked byte");

    a_err_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_result_reg.status != smap_pkg::STATUS_OK
        |-> out_result_reg.address == 32'hFFFF_FFFF && !out_result_reg.was_xor_form)
        else $error("failed verdict carries an address");

endmodule

`default_nettype wire

// ----- hw/rtl/smap_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// smap_core
// Parse state and per-byte update logic; forms the result on the last byte.
// ----------------------------------------------------------------------------
module smap_core #(
    parameter int MAX_PACKET_BYTES = smap_pkg::MAX_PACKET_BYTES
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic [7:0]       data_byte,
    input  wire logic             end_of_packet,
    output smap_pkg::result_t     result
);

    localparam int CW    = $clog2(MAX_PACKET_BYTES + 1);
    localparam int CMP_W = 18;

    localparam logic [CW-1:0]    MAX_CNT = CW'(MAX_PACKET_BYTES);
    localparam logic [CW-1:0]    HDR_CNT = CW'(smap_pkg::HDR_BYTES);

    logic [CW-1:0] byte_count_reg,       byte_count_next;
    logic [15:0]   message_type_reg,     message_type_next;
    logic [15:0]   declared_length_reg,  declared_length_next;
    logic [31:0]   magic_cookie_reg,     magic_cookie_next;
    logic [15:0]   attribute_type_reg,   attribute_type_next;
    logic [15:0]   attribute_length_reg, attribute_length_next;
    logic [CW-1:0] attribute_offset_reg, attribute_offset_next;
    logic          address_found_reg,    address_found_next;
    logic [31:0]   found_address_reg,    found_address_next;
    logic          found_xor_form_reg,   found_xor_form_next;

    logic [CW-1:0]    pos;
    logic             in_range;
    logic [CW-1:0]    body_pos;
    logic             in_body;
    logic [CW-1:0]    rel_raw;
    logic [CW-1:0]    rel;
    logic [CMP_W-1:0] attr_span;
    logic             new_attr;
    logic             is_addr_type;
    logic             addr_byte;
    logic [CMP_W-1:0] body_seen;

    always_comb
    begin
        message_type_next     = message_type_reg;
        declared_length_next  = declared_length_reg;
        magic_cookie_next     = magic_cookie_reg;
        attribute_type_next   = attribute_type_reg;
        attribute_length_next = attribute_length_reg;
        attribute_offset_next = attribute_offset_reg;
        address_found_next    = address_found_reg;
        found_address_next    = found_address_reg;
        found_xor_form_next   = found_xor_form_reg;

        pos             = byte_count_reg;
        in_range        = pos < MAX_CNT;
        byte_count_next = in_range ? pos + CW'(1) : pos;
        body_pos        = pos - HDR_CNT;
        in_body         = in_range && (pos >= HDR_CNT) &&
                          ({{(CMP_W-CW){1'b0}}, body_pos} <
                           {{(CMP_W-16){1'b0}}, declared_length_reg});

        // A new attribute starts once the previous header and padded value are passed.
        rel_raw   = body_pos - attribute_offset_reg;
        attr_span = CMP_W'(4) +
                    (({{(CMP_W-16){1'b0}}, attribute_length_reg} + CMP_W'(3)) &
                     ~CMP_W'(3));
        new_attr  = (rel_raw >= CW'(4)) &&
                    ({{(CMP_W-CW){1'b0}}, rel_raw} >= attr_span);
        rel       = new_attr ? '0 : rel_raw;

        is_addr_type = (attribute_type_reg == smap_pkg::ATTR_MAPPED) ||
                       (attribute_type_reg == smap_pkg::ATTR_XOR_MAPPED);
        addr_byte    = 1'b0;

        if (in_range && (pos < HDR_CNT))
        begin
            if (pos < CW'(2))
            begin
                message_type_next = {message_type_reg[7:0], data_byte};
            end
            else if (pos < CW'(4))
            begin
                declared_length_next = {declared_length_reg[7:0], data_byte};
            end
            else if (pos < CW'(8))
            begin
                magic_cookie_next = {magic_cookie_reg[23:0], data_byte};
            end
        end
        else if (in_body)
        begin
            if (new_attr)
            begin
                attribute_offset_next = body_pos;
            end

            if (rel == CW'(0))
            begin
                attribute_type_next = {data_byte, 8'h00};
            end
            else if (rel == CW'(1))
            begin
                attribute_type_next = {attribute_type_reg[15:8], data_byte};
            end
            else if (rel == CW'(2))
            begin
                attribute_length_next = {data_byte, 8'h00};
            end
            else if (rel == CW'(3))
            begin
                attribute_length_next = {attribute_length_reg[15:8], data_byte};
            end
            else
            begin
                // Address bytes of the first usable address attribute whose header
                // and first eight value bytes lie inside the declared body.
                addr_byte = (rel >= CW'(8)) && (rel <= CW'(11)) && !address_found_reg &&
                            is_addr_type && (attribute_length_reg >= 16'd8) &&
                            (({{(CMP_W-CW){1'b0}}, attribute_offset_next} + CMP_W'(12)) <=
                             {{(CMP_W-16){1'b0}}, declared_length_reg});
                if (addr_byte)
                begin
                    found_address_next = {found_address_reg[23:0], data_byte};
                    if (rel == CW'(11))
                    begin
                        address_found_next  = 1'b1;
                        found_xor_form_next =
                            (attribute_type_reg == smap_pkg::ATTR_XOR_MAPPED);
                    end
                end
            end
        end
    end

    // Verdict from the state as it stands after the current byte.
    always_comb
    begin
        body_seen = {{(CMP_W-CW){1'b0}}, byte_count_next - HDR_CNT};
        result.address      = 32'hFFFF_FFFF;
        result.was_xor_form = 1'b0;
        if (byte_count_next < HDR_CNT)
        begin
            result.status = smap_pkg::STATUS_BAD_LENGTH;
        end
        else if (message_type_next != smap_pkg::TYPE_BINDING_RESPONSE)
        begin
            result.status = smap_pkg::STATUS_NOT_BINDING;
        end
        else if ({{(CMP_W-16){1'b0}}, declared_length_next} > body_seen)
        begin
            result.status = smap_pkg::STATUS_BAD_LENGTH;
        end
        else if (!address_found_next)
        begin
            result.status = smap_pkg::STATUS_NO_ADDRESS;
        end
        else
        begin
            result.status       = smap_pkg::STATUS_OK;
            result.address      = found_xor_form_next ?
                                  (found_address_next ^ magic_cookie_next) :
                                  found_address_next;
            result.was_xor_form = found_xor_form_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg       <= '0;
            message_type_reg     <= '0;
            declared_length_reg  <= '0;
            magic_cookie_reg     <= '0;
            attribute_type_reg   <= '0;
            attribute_length_reg <= '0;
            attribute_offset_reg <= '0;
            address_found_reg    <= 1'b0;
            found_address_reg    <= '0;
            found_xor_form_reg   <= 1'b0;
        end
        else if (step && end_of_packet)
        begin
            byte_count_reg       <= '0;
            message_type_reg     <= '0;
            declared_length_reg  <= '0;
            magic_cookie_reg     <= '0;
            attribute_type_reg   <= '0;
            attribute_length_reg <= '0;
            attribute_offset_reg <= '0;
            address_found_reg    <= 1'b0;
            found_address_reg    <= '0;
            found_xor_form_reg   <= 1'b0;
        end
        else if (step)
        begin
            byte_count_reg       <= byte_count_next;
            message_type_reg     <= message_type_next;
            declared_length_reg  <= declared_length_next;
            magic_cookie_reg     <= magic_cookie_next;
            attribute_type_reg   <= attribute_type_next;
            attribute_length_reg <= attribute_length_next;
            attribute_offset_reg <= attribute_offset_next;
            address_found_reg    <= address_found_next;
            found_address_reg    <= found_address_next;
            found_xor_form_reg   <= found_xor_form_next;
        end
    end

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= MAX_CNT)
        else $error("byte count passed the packet limit");

    a_eop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && end_of_packet |=> byte_count_reg == '0 && !address_found_reg)
        else $error("parse state not cleared after last byte");

    a_found_holds: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(address_found_reg) |-> $past(step && end_of_packet))
        else $error("address flag dropped inside a packet");

    a_xor_needs_addr: assert property (@(posedge clk) disable iff (!rst_n)
        found_xor_form_reg |-> address_found_reg)
        else $error("xor form marked without an address");

endmodule

`default_nettype wire
